FILE: src/whf3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package whf3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COLOR_W   = 32;
    localparam int PIX_W     = COLOR_W + 1;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int ROW_W     = HEIGHT_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } op_t;

    typedef struct packed {
        logic               filled;
        logic [COLOR_W-1:0] color;
    } pix_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        pix_t              pix;
        logic              emit;
        logic              interior;
        logic              last;
    } stage_t;

endpackage

`default_nettype wire

FILE: src/whf3_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module whf3_ram #(
    parameter int WIDTH  = 33,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/whf3_window.sv
`timescale 1ns / 1ps
`default_nettype none

module whf3_window
    import whf3_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               shift,
    input  wire pix_t               top,
    input  wire pix_t               mid,
    input  wire pix_t               pix,
    input  wire logic               interior,
    output logic      [COLOR_W-1:0] color
);

    pix_t win_reg  [9];
    pix_t win_next [9];
    pix_t pick_orth;
    pix_t pick;

    // columns move left, new column enters on the right
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            win_next[k*3+0] = win_reg[k*3+1];
            win_next[k*3+1] = win_reg[k*3+2];
        end
        win_next[2] = top;
        win_next[5] = mid;
        win_next[8] = pix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // orthogonal: below, above, right, left
    always_comb
    begin
        if (win_next[7].filled)
            pick_orth = win_next[7];
        else if (win_next[1].filled)
            pick_orth = win_next[1];
        else if (win_next[5].filled)
            pick_orth = win_next[5];
        else if (win_next[3].filled)
            pick_orth = win_next[3];
        else
            pick_orth = win_next[4];
    end

    // diagonals override: down-right, up-left, down-left, up-right
    always_comb
    begin
        if (win_next[8].filled)
            pick = win_next[8];
        else if (win_next[0].filled)
            pick = win_next[0];
        else if (win_next[6].filled)
            pick = win_next[6];
        else if (win_next[2].filled)
            pick = win_next[2];
        else
            pick = pick_orth;
    end

    assign color = (!win_next[4].filled && interior) ? pick.color : win_next[4].color;

endmodule

`default_nettype wire

FILE: src/warp_hole_fill_3x3.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake             payload
// in       input      in_valid / in_ready   op, pixel_color, pixel_filled
// out      output     out_valid / out_ready out_color, out_last
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle unless the output stalls; the transaction that completes a window
// loads the window stage and registered line buffer read, then the output register
// reset clears counters, window and output valid, geometry returns to 640 x 480
// line buffers are not cleared; an entry can be read before it is first written
// a stalled output holds the pipeline stage, and in_ready drops only while it is full

module warp_hole_fill_3x3
    import whf3_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 op,
    input  wire logic [COLOR_W-1:0]   pixel_color,
    input  wire logic                 pixel_filled,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic      [COLOR_W-1:0]   out_color,
    output logic                      out_last,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data
);

    logic [ADDR_W-1:0]   w_last_reg, w_last_next;
    logic [ADDR_W-1:0]   w_m2_reg, w_m2_next;
    logic [HEIGHT_W-1:0] h_last_reg, h_last_next;
    logic [HEIGHT_W-1:0] h_m2_reg, h_m2_next;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                cfg_wr;

    logic [ADDR_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [ADDR_W-1:0]   ecol_reg, ecol_next;
    logic [HEIGHT_W-1:0] erow_reg, erow_next;

    logic                s1_valid_reg, s1_valid_next;
    stage_t              s1_reg, s1_next;
    logic                s1_adv;

    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  out_color_reg, out_color_next;
    logic                out_last_reg, out_last_next;

    logic                accept;
    logic                draining;
    logic                take;
    logic                emit;
    logic                interior;
    logic                last;
    pix_t                pix_in;
    pix_t                mid_rd;
    pix_t                top_rd;
    logic [COLOR_W-1:0]  fill_color;

    // geometry registers, kept in clamped form
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        if (cfg_data[WIDTH_W-1:0] < WIDTH_MIN)
            w_eff = WIDTH_MIN;
        else if (cfg_data[WIDTH_W-1:0] > WIDTH_MAX)
            w_eff = WIDTH_MAX;
        else
            w_eff = cfg_data[WIDTH_W-1:0];
        if (cfg_data[HEIGHT_W-1:0] < HEIGHT_MIN)
            h_eff = HEIGHT_MIN;
        else
            h_eff = cfg_data[HEIGHT_W-1:0];
    end

    always_comb
    begin
        w_last_next = w_last_reg;
        w_m2_next   = w_m2_reg;
        h_last_next = h_last_reg;
        h_m2_next   = h_m2_reg;
        if (cfg_wr)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:
                begin
                    w_last_next = ADDR_W'(w_eff - WIDTH_W'(1));
                    w_m2_next   = ADDR_W'(w_eff - WIDTH_W'(2));
                end
                REG_IMAGE_HEIGHT:
                begin
                    h_last_next = h_eff - HEIGHT_W'(1);
                    h_m2_next   = h_eff - HEIGHT_W'(2);
                end
                default:
                begin
                    w_last_next = w_last_reg;
                end
            endcase
        end
    end

    // input stage: position bookkeeping
    assign in_ready = !s1_valid_reg || s1_adv;
    assign accept   = in_valid && in_ready;
    assign draining = row_reg > {1'b0, h_last_reg};
    assign take     = accept && (draining || op_t'(op) != OP_FLUSH);
    assign emit     = (row_reg >= ROW_W'(2)) || (row_reg == ROW_W'(1) && col_reg != '0);
    assign interior = (erow_reg != '0) && (erow_reg <= h_m2_reg)
                      && (ecol_reg != '0) && (ecol_reg <= w_m2_reg);
    assign last     = (erow_reg == h_last_reg) && (ecol_reg == w_last_reg);

    always_comb
    begin
        if (draining)
            pix_in = '0;
        else
            pix_in = '{filled: pixel_filled, color: pixel_color};
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        ecol_next = ecol_reg;
        erow_next = erow_reg;
        if (cfg_wr || (take && emit && last))
        begin
            col_next  = '0;
            row_next  = '0;
            ecol_next = '0;
            erow_next = '0;
        end
        else if (take)
        begin
            if (col_reg == w_last_reg)
            begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + ADDR_W'(1);
            end
            if (emit)
            begin
                if (ecol_reg == w_last_reg)
                begin
                    ecol_next = '0;
                    erow_next = erow_reg + HEIGHT_W'(1);
                end
                else
                begin
                    ecol_next = ecol_reg + ADDR_W'(1);
                end
            end
        end
    end

    // window stage
    assign s1_adv = s1_valid_reg && (!s1_reg.emit || !out_valid_reg || out_ready);

    always_comb
    begin
        s1_next = s1_reg;
        if (take)
        begin
            s1_next = '{addr: col_reg, pix: pix_in, emit: emit,
                        interior: interior, last: last};
        end
        if (take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    whf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.addr),
        .wr_data (s1_reg.pix),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (mid_rd)
    );

    whf3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_reg.addr),
        .wr_data (mid_rd),
        .rd_en   (take),
        .rd_addr (col_reg),
        .rd_data (top_rd)
    );

    whf3_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (s1_adv),
        .top      (top_rd),
        .mid      (mid_rd),
        .pix      (s1_reg.pix),
        .interior (s1_reg.interior),
        .color    (fill_color)
    );

    // output register
    always_comb
    begin
        out_color_next = out_color_reg;
        out_last_next  = out_last_reg;
        if (s1_adv && s1_reg.emit)
        begin
            out_valid_next = 1'b1;
            out_color_next = fill_color;
            out_last_next  = s1_reg.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_color = out_color_reg;
    assign out_last  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_last_reg    <= ADDR_W'(WIDTH_RESET - WIDTH_W'(1));
            w_m2_reg      <= ADDR_W'(WIDTH_RESET - WIDTH_W'(2));
            h_last_reg    <= HEIGHT_RESET - HEIGHT_W'(1);
            h_m2_reg      <= HEIGHT_RESET - HEIGHT_W'(2);
            col_reg       <= '0;
            row_reg       <= '0;
            ecol_reg      <= '0;
            erow_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            w_last_reg    <= w_last_next;
            w_m2_reg      <= w_m2_next;
            h_last_reg    <= h_last_next;
            h_m2_reg      <= h_m2_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            ecol_reg      <= ecol_next;
            erow_reg      <= erow_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg        <= s1_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire
